// File: sv/mimu_pkg.sv
package mimu_pkg;

  localparam int DATA_W         = 64;
  localparam int WORD_BITS_DEF  = 64;
  localparam int MIN_MODULUS    = 2;
  localparam int PMOD_RESET     = 2;
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_ADDR_W     = 4;

  // register index, taken from paddr[3] (8-byte stride)
  localparam logic [0:0] REG_PMOD = 1'b0;

  typedef enum logic [1:0] {
    ST_OK             = 2'd0,
    ST_SMALL_MOD      = 2'd1,
    ST_NOT_INVERTIBLE = 2'd2
  } status_t;

  typedef struct packed {
    logic [DATA_W-1:0] factor;
    logic [DATA_W-1:0] q_last;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] product;
    status_t           status;
  } out_item_t;

endpackage

// File: sv/mimu_apb_regs.sv
module mimu_apb_regs #(
  parameter int WORD_BITS = mimu_pkg::WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mimu_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mimu_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mimu_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output logic [WORD_BITS-1:0]            pmod
);
  import mimu_pkg::*;

  logic [WORD_BITS-1:0] pmod_r;
  logic [0:0]           reg_idx;
  logic                 wr_en;

  // only the low WORD_BITS of the modulus are ever used, so only those are kept
  assign reg_idx = paddr[CFG_ADDR_W-1 -: 1];
  assign wr_en   = psel && penable && pwrite && (reg_idx == REG_PMOD);
  assign pready  = 1'b1;
  assign pmod    = pmod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pmod_r <= WORD_BITS'(PMOD_RESET);
    end else if (wr_en) begin
      pmod_r <= pwdata[WORD_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_PMOD) begin
      prdata = CFG_DATA_W'(pmod_r);
    end
  end

endmodule

// File: sv/mimu_div_unit.sv
module mimu_div_unit #(
  parameter int WORD_BITS = mimu_pkg::WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] num,
  input  logic [WORD_BITS-1:0] den,
  input  logic [WORD_BITS-1:0] addend,
  input  logic [WORD_BITS-1:0] modulus,
  output logic                 done,
  output logic [WORD_BITS-1:0] rem,
  output logic [WORD_BITS-1:0] acc
);
  import mimu_pkg::*;

  localparam int W     = WORD_BITS;
  localparam int CNT_W = $clog2(W);

  logic [W-1:0]     rem_r, num_r, acc_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;

  logic [W:0]   shifted, diff;
  logic         qbit;
  logic [W+1:0] hsum, m1, m2;
  logic [W-1:0] rem_nxt, acc_nxt;

  // restoring division step: one quotient bit per cycle, MSB first
  always_comb begin
    shifted = {rem_r, num_r[W-1]};
    diff    = shifted - {1'b0, den};
    qbit    = (shifted >= {1'b0, den});
    rem_nxt = qbit ? diff[W-1:0] : shifted[W-1:0];
  end

  // Horner step on the quotient bit: acc = 2*acc + qbit*addend mod m, sum < 3m
  always_comb begin
    m1   = {2'b00, modulus};
    m2   = {1'b0, modulus, 1'b0};
    hsum = {1'b0, acc_r, 1'b0} + (qbit ? {2'b00, addend} : '0);
    if (hsum >= m2) begin
      hsum = hsum - m2;
    end else if (hsum >= m1) begin
      hsum = hsum - m1;
    end
    acc_nxt = hsum[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        num_r  <= num;
        rem_r  <= '0;
        acc_r  <= '0;
        cnt_r  <= CNT_W'(W - 1);
      end else if (busy_r) begin
        num_r <= {num_r[W-2:0], qbit};
        rem_r <= rem_nxt;
        acc_r <= acc_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;
  assign acc  = acc_r;

endmodule

// File: sv/modular_inverse_multiply_unit.sv
// channel   ports                                          request moved when
// -------   --------------------------------------------   ---------------------------------
// input     start, busy, in_item                           start high and busy low
// result    out_valid, out_item                            out_valid high, one cycle only
// config    psel penable pwrite paddr pwdata prdata pready psel, penable, pwrite, pready high
//
// One request at a time; busy stays high until the result is issued.
// The Euclid steps, the reduction of the factor and the final multiply each take one pass
// of the shared divide / Horner unit; q_last not invertible: no factor or multiply pass.
// Modulus below two: result in the next cycle.
// Reset: synchronous, modulus (byte address 0) back to 2; the receiver cannot stall results.
module modular_inverse_multiply_unit #(
  parameter int WORD_BITS = mimu_pkg::WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  mimu_pkg::in_item_t              in_item,
  output logic                            out_valid,
  output mimu_pkg::out_item_t             out_item,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mimu_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mimu_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mimu_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import mimu_pkg::*;

  localparam int W = WORD_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_VMOD, S_CHECK, S_EDIV, S_FMOD, S_MUL
  } state_t;

  state_t       state_r;
  logic [W-1:0] pmod;
  logic [W-1:0] m_r, f_r, r_r, nr_r, c_r, nc_r;
  logic         div_start_r;
  logic [W-1:0] div_num_r, div_den_r, div_add_r;
  logic         div_done;
  logic [W-1:0] div_rem, div_acc;
  logic         out_valid_r;
  out_item_t    out_item_r;
  logic [W:0]   sdiff;
  logic [W-1:0] c_new;

  mimu_apb_regs #(.WORD_BITS(WORD_BITS)) u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .pmod
  );

  mimu_div_unit #(.WORD_BITS(WORD_BITS)) u_div (
    .clk, .rst_n,
    .start   (div_start_r),
    .num     (div_num_r),
    .den     (div_den_r),
    .addend  (div_add_r),
    .modulus (m_r),
    .done    (div_done),
    .rem     (div_rem),
    .acc     (div_acc)
  );

  // c - q*nc mod m, both operands already below m
  always_comb begin
    sdiff = {1'b0, c_r} - {1'b0, div_acc};
    c_new = sdiff[W] ? (sdiff[W-1:0] + m_r) : sdiff[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            m_r <= pmod;
            f_r <= in_item.factor[W-1:0];
            if (pmod < W'(MIN_MODULUS)) begin
              out_valid_r        <= 1'b1;
              out_item_r.product <= '0;
              out_item_r.status  <= ST_SMALL_MOD;
            end else begin
              div_num_r   <= in_item.q_last[W-1:0];
              div_den_r   <= pmod;
              div_add_r   <= '0;
              div_start_r <= 1'b1;
              state_r     <= S_VMOD;
            end
          end
        end
        S_VMOD: begin
          if (div_done) begin
            nr_r    <= div_rem;
            r_r     <= m_r;
            c_r     <= '0;
            nc_r    <= W'(1);
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (nr_r == '0) begin
            if (r_r == W'(1)) begin
              div_num_r   <= f_r;
              div_den_r   <= m_r;
              div_add_r   <= '0;
              div_start_r <= 1'b1;
              state_r     <= S_FMOD;
            end else begin
              out_valid_r        <= 1'b1;
              out_item_r.product <= '0;
              out_item_r.status  <= ST_NOT_INVERTIBLE;
              state_r            <= S_IDLE;
            end
          end else begin
            // quotient r / nr and q*nc mod m come out of one pass
            div_num_r   <= r_r;
            div_den_r   <= nr_r;
            div_add_r   <= nc_r;
            div_start_r <= 1'b1;
            state_r     <= S_EDIV;
          end
        end
        S_EDIV: begin
          if (div_done) begin
            c_r     <= nc_r;
            nc_r    <= c_new;
            r_r     <= nr_r;
            nr_r    <= div_rem;
            state_r <= S_CHECK;
          end
        end
        S_FMOD: begin
          if (div_done) begin
            // divide by one so the quotient bits are the inverse itself
            div_num_r   <= c_r;
            div_den_r   <= W'(1);
            div_add_r   <= div_rem;
            div_start_r <= 1'b1;
            state_r     <= S_MUL;
          end
        end
        S_MUL: begin
          if (div_done) begin
            out_valid_r        <= 1'b1;
            out_item_r.product <= DATA_W'(div_acc);
            out_item_r.status  <= ST_OK;
            state_r            <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
